>>> rtl/core/bte_pkg.sv
`default_nettype none
package bte_pkg;

   localparam int MAX_GROUPS_DEF  = 8;
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int STAGE_COUNT_DEF = 3;

   localparam int KIND_W = 2;
   localparam int SIZE_W = 16;
   localparam int TIME_W = 24;
   localparam int THR_W  = 7;
   localparam int EST_W  = 26;
   localparam int NUM_W  = TIME_W + SIZE_W + 1;
   localparam int DEN_W  = SIZE_W + THR_W;

   localparam logic [EST_W-1:0] ESTIMATE_MAX = 26'd50331645;

   localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TIME  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

   localparam logic [1:0] MODE_SKIP  = 2'd0;
   localparam logic [1:0] MODE_SPLIT = 2'd2;

   localparam logic [2:0] REG_M_STEP      = 3'd0;
   localparam logic [2:0] REG_ENTRIES     = 3'd1;
   localparam logic [2:0] REG_GROUPS      = 3'd2;
   localparam logic [2:0] REG_CPU_MODES   = 3'd3;
   localparam logic [2:0] REG_BLAS_MODES  = 3'd4;

   typedef struct packed {
      logic accept;
      logic g_inc;
      logic e_clr;
      logic e_cmp;
      logic pick;
      logic s_inc;
      logic cap_a;
      logic cap_b;
      logic mul;
      logic sum;
      logic div_step;
      logic acc;
      logic fin;
      logic fin_ok;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic g_end;
      logic key_hit;
      logic range_ok;
      logic e_end;
      logic exact_hit;
      logic brk_hit;
      logic s_end;
      logic s_skip;
      logic interp;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> rtl/core/bte_ctrl.sv
`default_nettype none
module bte_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  bte_pkg::sts_type      sts,
   output bte_pkg::cmd_type      cmd
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_GWAIT  = 5'd1;
   localparam logic [4:0] ST_GCMP   = 5'd2;
   localparam logic [4:0] ST_RANGE  = 5'd3;
   localparam logic [4:0] ST_EWAIT  = 5'd4;
   localparam logic [4:0] ST_ECMP   = 5'd5;
   localparam logic [4:0] ST_PICK   = 5'd6;
   localparam logic [4:0] ST_SCHK   = 5'd7;
   localparam logic [4:0] ST_AWAIT  = 5'd8;
   localparam logic [4:0] ST_ACAP   = 5'd9;
   localparam logic [4:0] ST_BWAIT  = 5'd10;
   localparam logic [4:0] ST_BCAP   = 5'd11;
   localparam logic [4:0] ST_MUL    = 5'd12;
   localparam logic [4:0] ST_SUM    = 5'd13;
   localparam logic [4:0] ST_DIV    = 5'd14;
   localparam logic [4:0] ST_ACC    = 5'd15;
   localparam logic [4:0] ST_FIN    = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       ok_ff, ok_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      cmd      = '0;
      cmd.fin_ok = ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.is_query) state_in = ST_GWAIT;
            end
         end
         ST_GWAIT: begin
            if (sts.g_end) begin
               ok_in    = 1'b0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_GCMP;
            end
         end
         ST_GCMP: begin
            if (sts.key_hit) begin
               state_in = ST_RANGE;
            end else begin
               cmd.g_inc = 1'b1;
               state_in  = ST_GWAIT;
            end
         end
         ST_RANGE: begin
            if (sts.range_ok) begin
               cmd.e_clr = 1'b1;
               state_in  = ST_EWAIT;
            end else begin
               ok_in    = 1'b0;
               state_in = ST_FIN;
            end
         end
         ST_EWAIT: state_in = sts.e_end ? ST_PICK : ST_ECMP;
         ST_ECMP: begin
            cmd.e_cmp = 1'b1;
            state_in  = ST_EWAIT;
         end
         ST_PICK: begin
            if (sts.exact_hit || sts.brk_hit) begin
               cmd.pick = 1'b1;
               state_in = ST_SCHK;
            end else begin
               ok_in    = 1'b0;
               state_in = ST_FIN;
            end
         end
         ST_SCHK: begin
            if (sts.s_end) begin
               ok_in    = 1'b1;
               state_in = ST_FIN;
            end else if (sts.s_skip) begin
               cmd.s_inc = 1'b1;
            end else begin
               state_in = ST_AWAIT;
            end
         end
         ST_AWAIT: state_in = ST_ACAP;
         ST_ACAP: begin
            cmd.cap_a = 1'b1;
            state_in  = sts.interp ? ST_BWAIT : ST_MUL;
         end
         ST_BWAIT: state_in = ST_BCAP;
         ST_BCAP: begin
            cmd.cap_b = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_SCHK;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/bte_datapath.sv
`default_nettype none
module bte_datapath #(
   parameter int MAX_GROUPS  = bte_pkg::MAX_GROUPS_DEF,
   parameter int MAX_ENTRIES = bte_pkg::MAX_ENTRIES_DEF,
   parameter int STAGE_COUNT = bte_pkg::STAGE_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bte_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [2:0]                    req_group_slot,
   input  wire logic [3:0]                    req_entry_slot,
   input  wire logic [2:0]                    req_time_slot,
   input  wire logic [bte_pkg::SIZE_W-1:0]    req_n_size,
   input  wire logic [bte_pkg::SIZE_W-1:0]    req_k_size,
   input  wire logic [bte_pkg::SIZE_W-1:0]    req_m_size,
   input  wire logic [bte_pkg::TIME_W-1:0]    req_time_value,
   input  wire logic [bte_pkg::THR_W-1:0]     req_threads,
   input  wire logic                          req_cpu_only,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ok,
   output logic [bte_pkg::EST_W-1:0]          rsp_estimate,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [4:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   input  bte_pkg::cmd_type                   cmd,
   output bte_pkg::sts_type                   sts
);

   localparam int SW   = bte_pkg::SIZE_W;
   localparam int TW   = bte_pkg::TIME_W;
   localparam int NW   = bte_pkg::NUM_W;
   localparam int DW   = bte_pkg::DEN_W;
   localparam int EW   = bte_pkg::EST_W;
   localparam int SLOTS = 2 * STAGE_COUNT;
   localparam int KDEP = MAX_GROUPS;
   localparam int EDEP = MAX_GROUPS * MAX_ENTRIES;
   localparam int TDEP = EDEP * SLOTS;
   localparam int KAW  = (KDEP > 1) ? $clog2(KDEP) : 1;
   localparam int EAW  = (EDEP > 1) ? $clog2(EDEP) : 1;
   localparam int TAW  = (TDEP > 1) ? $clog2(TDEP) : 1;
   localparam int GCW  = $clog2(MAX_GROUPS + 1);
   localparam int ECW  = $clog2(MAX_ENTRIES + 1);
   localparam int SCW  = $clog2(STAGE_COUNT + 1);
   localparam int DCW  = $clog2(NW);
   localparam int RW   = SW + ECW;

   logic [15:0] m_step_ff;
   logic [4:0]  ent_used_ff;
   logic [3:0]  grp_used_ff;
   logic [5:0]  cpu_modes_ff;
   logic [5:0]  blas_modes_ff;
   logic        csr_wr;

   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_step_ff     <= 16'd1;
         ent_used_ff   <= 5'd1;
         grp_used_ff   <= 4'd0;
         cpu_modes_ff  <= 6'd0;
         blas_modes_ff <= 6'd0;
      end else if (csr_wr) begin
         case (paddr[4:2])
            bte_pkg::REG_M_STEP:     m_step_ff     <= pwdata[15:0];
            bte_pkg::REG_ENTRIES:    ent_used_ff   <= pwdata[4:0];
            bte_pkg::REG_GROUPS:     grp_used_ff   <= pwdata[3:0];
            bte_pkg::REG_CPU_MODES:  cpu_modes_ff  <= pwdata[5:0];
            bte_pkg::REG_BLAS_MODES: blas_modes_ff <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         bte_pkg::REG_M_STEP:     prdata = {16'd0, m_step_ff};
         bte_pkg::REG_ENTRIES:    prdata = {27'd0, ent_used_ff};
         bte_pkg::REG_GROUPS:     prdata = {28'd0, grp_used_ff};
         bte_pkg::REG_CPU_MODES:  prdata = {26'd0, cpu_modes_ff};
         bte_pkg::REG_BLAS_MODES: prdata = {26'd0, blas_modes_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   logic [GCW-1:0] ng;
   logic [ECW-1:0] ne;
   assign ng = (32'(grp_used_ff) > MAX_GROUPS) ? GCW'(MAX_GROUPS) : GCW'(grp_used_ff);
   assign ne = (32'(ent_used_ff) > MAX_ENTRIES) ? ECW'(MAX_ENTRIES) : ECW'(ent_used_ff);

   logic [31:0]    qkey_ff;
   logic [SW-1:0]  qm_ff;
   logic [6:0]     qthr_ff;
   logic           qcpu_ff;
   logic [GCW-1:0] g_ff;
   logic [ECW-1:0] e_ff;
   logic [SCW-1:0] s_ff;
   logic [DCW-1:0] dcnt_ff;
   logic           fx_ff, fb_ff, interp_ff, second_ff;
   logic [ECW-1:0] ex_ff, eb_ff, sel_e_ff;
   logic [SW-1:0]  prev_ff, lo_ff, hi_ff, span_ff, dlt_ff;
   logic [TW-1:0]  a_ff, b_ff;
   logic [TW+SW-1:0] pa_ff, pb_ff;
   logic [NW-1:0]  nsh_ff;
   logic [DW-1:0]  rem_ff, den_ff;
   logic [EW-1:0]  acc_ff;
   logic           rsp_valid_ff, rsp_ok_ff;
   logic [EW-1:0]  rsp_est_ff;

   logic [31:0] key_mem [KDEP];
   logic [SW-1:0] size_mem [EDEP];
   logic [TW-1:0] time_mem [TDEP];
   logic [31:0]   key_q_ff;
   logic [SW-1:0] size_q_ff;
   logic [TW-1:0] time_q_ff;

   logic        wr_item, key_we, size_we, time_we;
   logic [31:0] w_eaddr, w_taddr, r_eaddr, r_taddr, esel;
   logic [31:0] base;

   assign wr_item = cmd.accept && (req_kind != bte_pkg::KIND_QUERY);
   assign key_we  = wr_item && (req_kind == bte_pkg::KIND_KEY) &&
                    (32'(req_group_slot) < MAX_GROUPS);
   assign size_we = wr_item && (req_kind == bte_pkg::KIND_ENTRY) &&
                    (32'(req_group_slot) < MAX_GROUPS) &&
                    (32'(req_entry_slot) < MAX_ENTRIES);
   assign time_we = wr_item && (req_kind == bte_pkg::KIND_TIME) &&
                    (32'(req_group_slot) < MAX_GROUPS) &&
                    (32'(req_entry_slot) < MAX_ENTRIES) &&
                    (32'(req_time_slot) < SLOTS);
   assign w_eaddr = 32'(req_group_slot) * MAX_ENTRIES + 32'(req_entry_slot);
   assign w_taddr = w_eaddr * SLOTS + 32'(req_time_slot);
   assign r_eaddr = 32'(g_ff) * MAX_ENTRIES + 32'(e_ff);
   assign esel    = 32'(sel_e_ff) + 32'(second_ff);
   assign base    = qcpu_ff ? 32'd0 : 32'(STAGE_COUNT);
   assign r_taddr = (32'(g_ff) * MAX_ENTRIES + esel) * SLOTS + base + 32'(s_ff);

   always_ff @(posedge clock) begin
      if (key_we) key_mem[KAW'(req_group_slot)] <= {req_n_size, req_k_size};
      if (size_we) size_mem[w_eaddr[EAW-1:0]] <= req_m_size;
      if (time_we) time_mem[w_taddr[TAW-1:0]] <= req_time_value;
      key_q_ff  <= key_mem[g_ff[KAW-1:0]];
      size_q_ff <= size_mem[r_eaddr[EAW-1:0]];
      time_q_ff <= time_mem[r_taddr[TAW-1:0]];
   end

   logic [5:0]     modes;
   logic [31:0]    mode_v;
   logic [1:0]     mode_s;
   logic           split;
   logic [6:0]     thr_eff;
   logic [6:0]     dmul;
   logic [RW-1:0]  top_m;
   logic [DW:0]    trial;
   logic           qbit;
   logic [NW:0]    acc_in;

   assign modes   = qcpu_ff ? cpu_modes_ff : blas_modes_ff;
   assign mode_v  = 32'(modes) >> (2 * 32'(s_ff));
   assign mode_s  = mode_v[1:0];
   assign split   = (mode_s == bte_pkg::MODE_SPLIT);
   assign thr_eff = (qthr_ff == 7'd0) ? 7'd1 : qthr_ff;
   assign dmul    = split ? thr_eff : 7'd1;
   assign top_m   = RW'(m_step_ff) * RW'(ne);
   assign trial   = {rem_ff, nsh_ff[NW-1]};
   assign qbit    = (trial >= {1'b0, den_ff});
   assign acc_in  = (NW+1)'(acc_ff) + (NW+1)'(nsh_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         qkey_ff <= {req_n_size, req_k_size};
         qm_ff   <= req_m_size;
         qthr_ff <= req_threads;
         qcpu_ff <= req_cpu_only;
         g_ff    <= '0;
         fx_ff   <= 1'b0;
         fb_ff   <= 1'b0;
      end
      if (cmd.g_inc) g_ff <= g_ff + GCW'(1);
      if (cmd.e_clr) e_ff <= '0;
      if (cmd.e_cmp) begin
         if (!fx_ff && size_q_ff == qm_ff) begin
            fx_ff <= 1'b1;
            ex_ff <= e_ff;
         end
         if (e_ff != '0 && !fb_ff && prev_ff < qm_ff && qm_ff < size_q_ff) begin
            fb_ff <= 1'b1;
            eb_ff <= e_ff - ECW'(1);
            lo_ff <= prev_ff;
            hi_ff <= size_q_ff;
         end
         prev_ff <= size_q_ff;
         e_ff    <= e_ff + ECW'(1);
      end
      if (cmd.pick) begin
         sel_e_ff  <= fx_ff ? ex_ff : eb_ff;
         interp_ff <= !fx_ff;
         span_ff   <= hi_ff - lo_ff;
         dlt_ff    <= qm_ff - lo_ff;
         acc_ff    <= '0;
         s_ff      <= '0;
         second_ff <= 1'b0;
      end
      if (cmd.s_inc) s_ff <= s_ff + SCW'(1);
      if (cmd.cap_a) begin
         a_ff      <= time_q_ff;
         second_ff <= 1'b1;
      end
      if (cmd.cap_b) b_ff <= time_q_ff;
      if (cmd.mul) begin
         if (interp_ff) begin
            pa_ff <= (TW+SW)'(a_ff) * (TW+SW)'(span_ff - dlt_ff);
            pb_ff <= (TW+SW)'(b_ff) * (TW+SW)'(dlt_ff);
         end else begin
            pa_ff <= (TW+SW)'(a_ff);
            pb_ff <= '0;
         end
      end
      if (cmd.sum) begin
         nsh_ff  <= NW'(pa_ff) + NW'(pb_ff);
         den_ff  <= interp_ff ? DW'(span_ff) * DW'(dmul) : DW'(dmul);
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= qbit ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         nsh_ff  <= {nsh_ff[NW-2:0], qbit};
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
      if (cmd.acc) begin
         acc_ff    <= (acc_in > (NW+1)'(bte_pkg::ESTIMATE_MAX)) ?
                      bte_pkg::ESTIMATE_MAX : acc_in[EW-1:0];
         s_ff      <= s_ff + SCW'(1);
         second_ff <= 1'b0;
      end
      if (cmd.fin) begin
         rsp_ok_ff  <= cmd.fin_ok;
         rsp_est_ff <= cmd.fin_ok ? acc_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_estimate = rsp_est_ff;

   always_comb begin
      sts.is_query  = (req_kind == bte_pkg::KIND_QUERY);
      sts.g_end     = (g_ff == ng);
      sts.key_hit   = (key_q_ff == qkey_ff);
      sts.range_ok  = (qm_ff >= m_step_ff) && (RW'(qm_ff) <= top_m);
      sts.e_end     = (e_ff == ne);
      sts.exact_hit = fx_ff;
      sts.brk_hit   = fb_ff;
      sts.s_end     = (32'(s_ff) == STAGE_COUNT);
      sts.s_skip    = (mode_s == bte_pkg::MODE_SKIP);
      sts.interp    = interp_ff;
      sts.div_last  = (32'(dcnt_ff) == NW - 1);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire

>>> rtl/core/benchmark_table_time_estimator_top.sv
`default_nettype none
// channel  direction  handshake                  payload
// req      in         req_valid / req_stall      kind, slots, n/k/m sizes, time, threads, path
// rsp      out        rsp_valid / rsp_stall      ok, estimate
// csr      in         psel penable pwrite pready register writes and reads
//
// Write beats are accepted back to back while idle. A query holds req_stall high for the
// table search, then for each enabled stage runs the
// bit-serial divider (41 steps) behind the single stage-time memory port.
// Sync reset clears control state and CSRs (m_step, entries to 1); the table is undefined.
// A result waiting under rsp_stall does not block the next write beat.
module benchmark_table_time_estimator_top #(
   parameter int MAX_GROUPS  = bte_pkg::MAX_GROUPS_DEF,
   parameter int MAX_ENTRIES = bte_pkg::MAX_ENTRIES_DEF,
   parameter int STAGE_COUNT = bte_pkg::STAGE_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bte_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [2:0]                    req_group_slot,
   input  wire logic [3:0]                    req_entry_slot,
   input  wire logic [2:0]                    req_time_slot,
   input  wire logic [bte_pkg::SIZE_W-1:0]    req_n_size,
   input  wire logic [bte_pkg::SIZE_W-1:0]    req_k_size,
   input  wire logic [bte_pkg::SIZE_W-1:0]    req_m_size,
   input  wire logic [bte_pkg::TIME_W-1:0]    req_time_value,
   input  wire logic [bte_pkg::THR_W-1:0]     req_threads,
   input  wire logic                          req_cpu_only,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ok,
   output logic [bte_pkg::EST_W-1:0]          rsp_estimate,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [4:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   bte_pkg::cmd_type cmd;
   bte_pkg::sts_type sts;

   assign pready = 1'b1;

   bte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bte_datapath #(
      .MAX_GROUPS  (MAX_GROUPS),
      .MAX_ENTRIES (MAX_ENTRIES),
      .STAGE_COUNT (STAGE_COUNT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_kind),
      .req_group_slot (req_group_slot),
      .req_entry_slot (req_entry_slot),
      .req_time_slot  (req_time_slot),
      .req_n_size     (req_n_size),
      .req_k_size     (req_k_size),
      .req_m_size     (req_m_size),
      .req_time_value (req_time_value),
      .req_threads    (req_threads),
      .req_cpu_only   (req_cpu_only),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_estimate   (rsp_estimate),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
`default_nettype wire

>>> rtl/core/bte_checker.sv
`default_nettype none
module bte_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic [bte_pkg::KIND_W-1:0] req_kind,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic                       rsp_ok,
   input wire logic [bte_pkg::EST_W-1:0]  rsp_estimate
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_estimate))
      else $error("result changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_estimate == '0)
      else $error("failed estimate not zero");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_estimate <= bte_pkg::ESTIMATE_MAX)
      else $error("estimate above saturation");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == bte_pkg::KIND_QUERY |=> req_stall)
      else $error("query did not hold off input");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind benchmark_table_time_estimator_top bte_checker u_chk (.*);
`default_nettype wire
